@@ sv/wgbs_pkg.sv @@
// Package with the constants, types and arithmetic shared by the wind grid sampler.
`default_nettype none

package wgbs_pkg;

    localparam int GRID_ROWS = 181;
    localparam int GRID_COLS = 360;
    localparam int FRAC_BITS = 8;
    localparam int POS_FRAC = 8;

    localparam int VAL_W = 16;
    localparam int ROW_W = 8;
    localparam int COL_W = 9;
    localparam int LAT_W = 16;
    localparam int LON_W = 18;
    localparam int FRAC_W = FRAC_BITS + 1;
    localparam int WORD_W = 2 * VAL_W;

    localparam int LAT_90 = 90 * (1 << POS_FRAC);
    localparam int LON_360 = 360 * (1 << POS_FRAC);

    localparam logic signed [LAT_W-1:0] LAT_HI = LAT_W'(LAT_90);
    localparam logic signed [LAT_W-1:0] LAT_LO = LAT_W'(-LAT_90);
    localparam logic signed [LON_W:0] LON_FULL = (LON_W + 1)'(LON_360);

    localparam int HALF_COLS = GRID_COLS / 2;
    localparam int BANK_ROWS = (GRID_ROWS + 1) / 2;
    localparam int BANK_DEPTH = BANK_ROWS * HALF_COLS;
    localparam int BANK_AW = $clog2(BANK_DEPTH);
    localparam int NUM_BANKS = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } wgbs_op_t;

    typedef struct packed {
        logic               is_write;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [COL_W-1:0]   col1;
        logic [FRAC_W-1:0]  frac_x;
        logic [FRAC_W-1:0]  frac_y;
        logic [VAL_W-1:0]   east;
        logic [VAL_W-1:0]   north;
    } wgbs_entry_t;

    function automatic logic signed [VAL_W-1:0] lerp(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b,
        input logic [FRAC_W-1:0]       f
    );
        logic signed [VAL_W:0]          diff;
        logic signed [VAL_W+FRAC_W+1:0] prod;
        logic signed [VAL_W+FRAC_W+1:0] step;
        diff = $signed({b[VAL_W-1], b}) - $signed({a[VAL_W-1], a});
        prod = diff * $signed({1'b0, f});
        step = prod >>> FRAC_BITS;
        return a + $signed(step[VAL_W-1:0]);
    endfunction

endpackage

`default_nettype wire

@@ sv/wind_grid_bilinear_sampler_unit.sv @@
// Top level of the wind grid bilinear sampler.
// The block holds a 181 by 360 grid of east and north wind components and takes one item per
// clock while its queue has room: a write item loads one cell, and a sample item returns both
// components bilinearly interpolated at a latitude and longitude given in 1/256 degree. The
// grid lives in four memory banks split by row and column parity, so the four neighbors of a
// sample are read in the same cycle through one port per bank; a sample result passes the
// queue, the bank read registers and the two interpolation registers, and writes give no
// result. A four-item queue between the position mapping and the memory pipeline lets input
// stay open while a result waits. Cells that were never written read back as unknown values.
`default_nettype none

module wind_grid_bilinear_sampler_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                opcode,
    input  wire logic [wgbs_pkg::ROW_W-1:0]          cell_row,
    input  wire logic [wgbs_pkg::COL_W-1:0]          cell_col,
    input  wire logic signed [wgbs_pkg::VAL_W-1:0]   east_value,
    input  wire logic signed [wgbs_pkg::VAL_W-1:0]   north_value,
    input  wire logic signed [wgbs_pkg::LAT_W-1:0]   latitude,
    input  wire logic signed [wgbs_pkg::LON_W-1:0]   longitude,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [wgbs_pkg::VAL_W-1:0]        east_wind,
    output logic signed [wgbs_pkg::VAL_W-1:0]        north_wind
);

    logic                   keep;
    wgbs_pkg::wgbs_entry_t  entry;
    logic                   q_push;
    logic                   q_not_full;
    logic                   q_pop;
    logic                   q_not_empty;
    wgbs_pkg::wgbs_entry_t  q_head;

    wgbs_front u_front (
        .opcode      (opcode),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .east_value  (east_value),
        .north_value (north_value),
        .latitude    (latitude),
        .longitude   (longitude),
        .keep        (keep),
        .entry       (entry)
    );

    assign in_ready = q_not_full;
    assign q_push = in_valid && q_not_full && keep;

    wgbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (entry),
        .not_full   (q_not_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    wgbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .east_wind  (east_wind),
        .north_wind (north_wind)
    );

endmodule

`default_nettype wire

@@ sv/wgbs_front.sv @@
// Front end: classifies each item and maps sample positions to grid indices and fractions.
`default_nettype none

module wgbs_front (
    input  wire logic                                opcode,
    input  wire logic [wgbs_pkg::ROW_W-1:0]          cell_row,
    input  wire logic [wgbs_pkg::COL_W-1:0]          cell_col,
    input  wire logic signed [wgbs_pkg::VAL_W-1:0]   east_value,
    input  wire logic signed [wgbs_pkg::VAL_W-1:0]   north_value,
    input  wire logic signed [wgbs_pkg::LAT_W-1:0]   latitude,
    input  wire logic signed [wgbs_pkg::LON_W-1:0]   longitude,
    output logic                                     keep,
    output wgbs_pkg::wgbs_entry_t                    entry
);

    function automatic logic [wgbs_pkg::FRAC_W-1:0] frac_scale(
        input logic [wgbs_pkg::POS_FRAC-1:0] f8
    );
        logic [wgbs_pkg::POS_FRAC+wgbs_pkg::FRAC_BITS-1:0] wide;
        wide = {f8, {wgbs_pkg::FRAC_BITS{1'b0}}} >> wgbs_pkg::POS_FRAC;
        return wgbs_pkg::FRAC_W'(wide);
    endfunction

    logic signed [wgbs_pkg::LAT_W-1:0] lat_c;
    logic signed [wgbs_pkg::LAT_W:0]   gy_s;
    logic [wgbs_pkg::LAT_W-1:0]        gy;
    logic [wgbs_pkg::ROW_W-1:0]        y0_raw;
    logic [wgbs_pkg::ROW_W-1:0]        y0;
    logic [wgbs_pkg::FRAC_W-1:0]       fy;
    logic signed [wgbs_pkg::LON_W:0]   lon0;
    logic signed [wgbs_pkg::LON_W:0]   lon1;
    logic signed [wgbs_pkg::LON_W:0]   lon2;
    logic signed [wgbs_pkg::LON_W:0]   lon3;
    logic [wgbs_pkg::COL_W-1:0]        x0_raw;
    logic [wgbs_pkg::COL_W-1:0]        x0;
    logic [wgbs_pkg::COL_W-1:0]        x1;
    logic                              is_sample;
    logic                              in_grid;

    always_comb
    begin
        if (latitude > wgbs_pkg::LAT_HI)
        begin
            lat_c = wgbs_pkg::LAT_HI;
        end
        else if (latitude < wgbs_pkg::LAT_LO)
        begin
            lat_c = wgbs_pkg::LAT_LO;
        end
        else
        begin
            lat_c = latitude;
        end
        gy_s = $signed({wgbs_pkg::LAT_HI[wgbs_pkg::LAT_W-1], wgbs_pkg::LAT_HI})
             - $signed({lat_c[wgbs_pkg::LAT_W-1], lat_c});
        gy = gy_s[wgbs_pkg::LAT_W-1:0];
        y0_raw = wgbs_pkg::ROW_W'(gy >> wgbs_pkg::POS_FRAC);
        if (y0_raw >= wgbs_pkg::ROW_W'(wgbs_pkg::GRID_ROWS - 1))
        begin
            y0 = wgbs_pkg::ROW_W'(wgbs_pkg::GRID_ROWS - 2);
            fy = wgbs_pkg::FRAC_W'(1 << wgbs_pkg::FRAC_BITS);
        end
        else
        begin
            y0 = y0_raw;
            fy = frac_scale(gy[wgbs_pkg::POS_FRAC-1:0]);
        end
    end

    always_comb
    begin
        lon0 = (wgbs_pkg::LON_W + 1)'(longitude);
        lon1 = lon0[wgbs_pkg::LON_W] ? lon0 + wgbs_pkg::LON_FULL : lon0;
        lon2 = lon1[wgbs_pkg::LON_W] ? lon1 + wgbs_pkg::LON_FULL : lon1;
        lon3 = (lon2 >= wgbs_pkg::LON_FULL) ? lon2 - wgbs_pkg::LON_FULL : lon2;
        x0_raw = wgbs_pkg::COL_W'(lon3 >> wgbs_pkg::POS_FRAC);
        if (x0_raw >= wgbs_pkg::COL_W'(wgbs_pkg::GRID_COLS))
        begin
            x0 = x0_raw - wgbs_pkg::COL_W'(wgbs_pkg::GRID_COLS);
        end
        else
        begin
            x0 = x0_raw;
        end
        if (x0 == wgbs_pkg::COL_W'(wgbs_pkg::GRID_COLS - 1))
        begin
            x1 = '0;
        end
        else
        begin
            x1 = x0 + wgbs_pkg::COL_W'(1);
        end
    end

    always_comb
    begin
        is_sample = (opcode == wgbs_pkg::OP_SAMPLE);
        in_grid = (cell_row < wgbs_pkg::ROW_W'(wgbs_pkg::GRID_ROWS))
                && (cell_col < wgbs_pkg::COL_W'(wgbs_pkg::GRID_COLS));
        keep = is_sample || in_grid;
        entry.is_write = !is_sample;
        entry.east = east_value;
        entry.north = north_value;
        if (is_sample)
        begin
            entry.row = y0;
            entry.col = x0;
            entry.col1 = x1;
            entry.frac_x = frac_scale(lon3[wgbs_pkg::POS_FRAC-1:0]);
            entry.frac_y = fy;
        end
        else
        begin
            entry.row = cell_row;
            entry.col = cell_col;
            entry.col1 = cell_col;
            entry.frac_x = '0;
            entry.frac_y = '0;
        end
    end

endmodule

`default_nettype wire

@@ sv/wgbs_queue.sv @@
// Short queue of classified items between the front end and the grid pipeline.
`default_nettype none

module wgbs_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire wgbs_pkg::wgbs_entry_t push_entry,
    output logic                       not_full,
    input  wire logic                  pop,
    output logic                       not_empty,
    output wgbs_pkg::wgbs_entry_t      head
);

    wgbs_pkg::wgbs_entry_t              slot_reg [wgbs_pkg::QUEUE_DEPTH];
    logic [wgbs_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [wgbs_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [wgbs_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [wgbs_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [wgbs_pkg::QCNT_W-1:0]        count_reg;
    logic [wgbs_pkg::QCNT_W-1:0]        count_next;
    logic                               do_push;
    logic                               do_pop;

    always_comb
    begin
        not_full = (count_reg != wgbs_pkg::QCNT_W'(wgbs_pkg::QUEUE_DEPTH));
        not_empty = (count_reg != '0);
        do_push = push && not_full;
        do_pop = pop && not_empty;
        wr_ptr_next = do_push ? wr_ptr_reg + wgbs_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + wgbs_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + wgbs_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - wgbs_pkg::QCNT_W'(1);
        end
        head = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

@@ sv/wgbs_back.sv @@
// Back end: parity-banked grid memory and the two-stage bilinear interpolation pipeline.
`default_nettype none

module wgbs_back (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                q_valid,
    input  wire wgbs_pkg::wgbs_entry_t               q_head,
    output logic                                     q_pop,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [wgbs_pkg::VAL_W-1:0]        east_wind,
    output logic signed [wgbs_pkg::VAL_W-1:0]        north_wind
);

    localparam int V = wgbs_pkg::VAL_W;

    logic                              adv;
    logic                              a_valid_reg;
    wgbs_pkg::wgbs_entry_t             a_entry_reg;
    logic [wgbs_pkg::WORD_W-1:0]       rd_data_reg [wgbs_pkg::NUM_BANKS];
    logic                              m_valid_reg;
    logic [wgbs_pkg::FRAC_W-1:0]       m_fx_reg;
    logic [wgbs_pkg::FRAC_W-1:0]       m_fy_reg;
    logic                              m_rp_reg;
    logic                              m_cp_reg;
    logic [wgbs_pkg::WORD_W-1:0]       top0;
    logic [wgbs_pkg::WORD_W-1:0]       top1;
    logic [wgbs_pkg::WORD_W-1:0]       bot0;
    logic [wgbs_pkg::WORD_W-1:0]       bot1;
    logic [wgbs_pkg::WORD_W-1:0]       w_a;
    logic [wgbs_pkg::WORD_W-1:0]       w_b;
    logic [wgbs_pkg::WORD_W-1:0]       w_c;
    logic [wgbs_pkg::WORD_W-1:0]       w_d;
    logic                              h_valid_reg;
    logic [wgbs_pkg::FRAC_W-1:0]       h_fy_reg;
    logic signed [V-1:0]               h_east_top_reg;
    logic signed [V-1:0]               h_east_bot_reg;
    logic signed [V-1:0]               h_north_top_reg;
    logic signed [V-1:0]               h_north_bot_reg;
    logic                              out_valid_reg;
    logic signed [V-1:0]               east_reg;
    logic signed [V-1:0]               north_reg;

    assign adv = !out_valid_reg || out_ready;
    assign q_pop = adv && q_valid;

    for (genvar g = 0; g < wgbs_pkg::NUM_BANKS; g++)
    begin : g_bank
        localparam logic BANK_RP = 1'(g / 2);
        localparam logic BANK_CP = 1'(g % 2);

        logic [wgbs_pkg::WORD_W-1:0]  bank_mem [wgbs_pkg::BANK_DEPTH];
        logic [wgbs_pkg::ROW_W-1:0]   bank_row;
        logic [wgbs_pkg::COL_W-1:0]   bank_col;
        logic [wgbs_pkg::BANK_AW-1:0] bank_addr;
        logic                         bank_we;

        always_comb
        begin
            bank_row = (a_entry_reg.row[0] == BANK_RP)
                     ? a_entry_reg.row : a_entry_reg.row + wgbs_pkg::ROW_W'(1);
            bank_col = (a_entry_reg.col[0] == BANK_CP) ? a_entry_reg.col : a_entry_reg.col1;
            bank_addr = wgbs_pkg::BANK_AW'(bank_row >> 1)
                      * wgbs_pkg::BANK_AW'(wgbs_pkg::HALF_COLS)
                      + wgbs_pkg::BANK_AW'(bank_col >> 1);
            bank_we = a_valid_reg && a_entry_reg.is_write
                    && (a_entry_reg.row[0] == BANK_RP) && (a_entry_reg.col[0] == BANK_CP);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (bank_we)
                begin
                    bank_mem[bank_addr] <= {a_entry_reg.east, a_entry_reg.north};
                end
                rd_data_reg[g] <= bank_mem[bank_addr];
            end
        end
    end

    always_comb
    begin
        top0 = m_rp_reg ? rd_data_reg[2] : rd_data_reg[0];
        top1 = m_rp_reg ? rd_data_reg[3] : rd_data_reg[1];
        bot0 = m_rp_reg ? rd_data_reg[0] : rd_data_reg[2];
        bot1 = m_rp_reg ? rd_data_reg[1] : rd_data_reg[3];
        w_a = m_cp_reg ? top1 : top0;
        w_b = m_cp_reg ? top0 : top1;
        w_c = m_cp_reg ? bot1 : bot0;
        w_d = m_cp_reg ? bot0 : bot1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= q_valid;
            m_valid_reg <= a_valid_reg && !a_entry_reg.is_write;
            h_valid_reg <= m_valid_reg;
            out_valid_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_entry_reg <= q_head;
            m_fx_reg <= a_entry_reg.frac_x;
            m_fy_reg <= a_entry_reg.frac_y;
            m_rp_reg <= a_entry_reg.row[0];
            m_cp_reg <= a_entry_reg.col[0];
            h_fy_reg <= m_fy_reg;
            h_east_top_reg <= wgbs_pkg::lerp(w_a[2*V-1:V], w_b[2*V-1:V], m_fx_reg);
            h_east_bot_reg <= wgbs_pkg::lerp(w_c[2*V-1:V], w_d[2*V-1:V], m_fx_reg);
            h_north_top_reg <= wgbs_pkg::lerp(w_a[V-1:0], w_b[V-1:0], m_fx_reg);
            h_north_bot_reg <= wgbs_pkg::lerp(w_c[V-1:0], w_d[V-1:0], m_fx_reg);
            east_reg <= wgbs_pkg::lerp(h_east_top_reg, h_east_bot_reg, h_fy_reg);
            north_reg <= wgbs_pkg::lerp(h_north_top_reg, h_north_bot_reg, h_fy_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign east_wind = east_reg;
    assign north_wind = north_reg;

endmodule

`default_nettype wire

@@ sv/wgbs_checker.sv @@
// Port-level checker for the wind grid sampler and its bind to the top level.
`default_nettype none

module wgbs_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic                                opcode,
    input wire logic [wgbs_pkg::ROW_W-1:0]          cell_row,
    input wire logic [wgbs_pkg::COL_W-1:0]          cell_col,
    input wire logic signed [wgbs_pkg::VAL_W-1:0]   east_value,
    input wire logic signed [wgbs_pkg::VAL_W-1:0]   north_value,
    input wire logic signed [wgbs_pkg::LAT_W-1:0]   latitude,
    input wire logic signed [wgbs_pkg::LON_W-1:0]   longitude,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic signed [wgbs_pkg::VAL_W-1:0]   east_wind,
    input wire logic signed [wgbs_pkg::VAL_W-1:0]   north_wind
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(east_wind) && $stable(north_wind))
        else $error("A waiting result item changed or vanished.");

    a_reset_out: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("A result item was offered right after reset.");

    a_reset_ready: assert property (@(posedge clk)
        $rose(rst_n) |-> in_ready)
        else $error("Input was not ready right after reset.");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) ##1 (in_valid && in_ready && opcode == wgbs_pkg::OP_WRITE) |=> !out_valid)
        else $error("A write item produced a result item.");

endmodule

bind wind_grid_bilinear_sampler_unit wgbs_checker u_wgbs_checker (.*);

`default_nettype wire
